/* src/dps_pkg.sv */
// dps_pkg: shared types and constants for the double-buffered pattern sequencer
// covers stream field widths, command and op codes, register indexes, queue and result words
// no dependencies
`default_nettype none

package dps_pkg;

  localparam int MaxStepsDef       = 64;
  localparam int DurationBitsDef   = 32;
  localparam int CorrectionBitsDef = 24;

  localparam int FUNC_W      = 3;
  localparam int IDX_W       = 6;
  localparam int DUR_W       = 32;
  localparam int PINS_W      = 3;
  localparam int CORR_W      = 24;
  localparam int LEN_W       = 7;
  localparam int STEP_OUT_W  = 6;
  localparam int CPR_W       = 16;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int S_TDATA_W   = 80;
  localparam int M_TDATA_W   = 16;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_WRITE  = 3'd1,
    FUNC_COMMIT = 3'd2,
    FUNC_START  = 3'd3,
    FUNC_SELECT = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_WRITE,
    OP_COMMIT,
    OP_START,
    OP_SELECT
  } op_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_RUN  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_MODE  = 2'd0,
    CFG_CORR_EN   = 2'd1,
    CFG_REPORT_EN = 2'd2,
    CFG_PERIOD    = 2'd3
  } cfg_e;

  typedef struct packed {
    op_e                       op;
    logic [IDX_W-1:0]          entry_index;
    logic [DUR_W-1:0]          step_duration;
    logic [PINS_W-1:0]         step_pins;
    logic signed [CORR_W-1:0]  step_correction;
    logic [LEN_W-1:0]          pattern_length;
    logic                      bank_choice;
  } item_t;

  // declared msb first, so pin_levels lands in the lowest bits
  typedef struct packed {
    logic                   switch_waiting;
    logic                   report_pulse;
    logic                   step_advanced;
    logic                   bank_now;
    logic [STEP_OUT_W-1:0]  step_now;
    logic                   led_level;
    logic [PINS_W-1:0]      pin_levels;
  } result_t;

endpackage

`default_nettype wire

/* src/dps_front.sv */
// dps_front: input side of the sequencer, unpacks and classifies stream words
// and holds them in a short queue for the back end; uses dps_pkg
`default_nettype none

module dps_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // entry_index, step_duration, step_pins, step_correction, pattern_length, bank_choice
  input  logic [dps_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [dps_pkg::FUNC_W-1:0]     s_axis_tuser,
  output logic                           q_valid_o,
  output dps_pkg::item_t                 q_item_o,
  input  logic                           q_pop_i
);
  import dps_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t             in_item;
  item_t             fifo_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              push;

  always_comb begin
    in_item.entry_index     = s_axis_tdata[5:0];
    in_item.step_duration   = s_axis_tdata[37:6];
    in_item.step_pins       = s_axis_tdata[40:38];
    in_item.step_correction = s_axis_tdata[64:41];
    in_item.pattern_length  = s_axis_tdata[71:65];
    in_item.bank_choice     = s_axis_tdata[72];
    unique case (func_e'(s_axis_tuser))
      FUNC_TICK:   in_item.op = OP_TICK;
      FUNC_WRITE:  in_item.op = OP_WRITE;
      FUNC_COMMIT: in_item.op = OP_COMMIT;
      FUNC_START:  in_item.op = OP_START;
      FUNC_SELECT: in_item.op = OP_SELECT;
      default:     in_item.op = OP_NONE;
    endcase
  end

  assign s_axis_tready = (cnt_q != CntW'(QUEUE_DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign q_item_o      = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_item;
    end
  end

endmodule

`default_nettype wire

/* src/dps_rem.sv */
// dps_rem: bit-serial remainder unit, one quotient bit per cycle
// reduces the report cycle counter after a period change; uses dps_pkg
`default_nettype none

module dps_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dps_pkg::CPR_W-1:0]  num_i,
  input  logic [dps_pkg::CPR_W-1:0]  den_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [dps_pkg::CPR_W-1:0]  rem_o
);
  import dps_pkg::*;

  localparam int CntW = $clog2(CPR_W);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [CPR_W-1:0]  num_q, den_q, rem_q, rem_d;
  logic [CPR_W:0]    trial;
  logic              last;

  assign trial  = {rem_q, num_q[CPR_W-1]};
  assign rem_d  = (trial >= {1'b0, den_q}) ? CPR_W'(trial - {1'b0, den_q}) : CPR_W'(trial);
  assign last   = (cnt_q == CntW'(CPR_W - 1));
  assign busy_o = busy_q;
  assign done_o = busy_q && last && !start_i;
  assign rem_o  = rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[CPR_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

endmodule

`default_nettype wire

/* src/dps_back.sv */
// dps_back: execution side of the sequencer with step memory, prefetch registers,
// playback state, config registers and the output register; uses dps_pkg and dps_rem
`default_nettype none

module dps_back #(
  parameter int MAX_STEPS       = dps_pkg::MaxStepsDef,
  parameter int DURATION_BITS   = dps_pkg::DurationBitsDef,
  parameter int CORRECTION_BITS = dps_pkg::CorrectionBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dps_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            q_valid_i,
  input  dps_pkg::item_t                  q_item_i,
  output logic                            q_pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pin_levels, led_level, step_now, bank_now, step_advanced, report_pulse, switch_waiting
  output logic [dps_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import dps_pkg::*;

  localparam int StepW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int NxtW   = StepW + 1;
  localparam int LenW   = $clog2(MAX_STEPS + 1);
  localparam int AddrW  = StepW + 1;
  localparam int Depth  = 2 ** AddrW;
  localparam int EntryW = DURATION_BITS + PINS_W + CORRECTION_BITS;
  localparam int SumW   = ((DURATION_BITS > CORRECTION_BITS) ? DURATION_BITS
                                                             : CORRECTION_BITS) + 2;
  localparam int LeftW  = SumW - 1;
  localparam logic signed [32:0] CorrMax = (33'sd1 <<< (CORRECTION_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] CorrMin = -CorrMax - 33'sd1;

  // step memory, entry = {correction, pins, duration}
  logic [EntryW-1:0]  entry_mem [Depth];
  logic [EntryW-1:0]  next_entry_q, zero_entry_q, load_entry, wdata;
  logic [AddrW-1:0]   waddr, addr_a, addr_b;
  logic               mem_we;

  logic [StepW-1:0]   cur_q, cur_d;
  logic [LeftW-1:0]   left_q, left_d, left_load;
  logic               act_q, act_d, pend_q, pend_d, hold_q, hold_d;
  logic [CPR_W-1:0]   cc_q, cc_d, period, cc_inc, rem_val;
  logic [LenW-1:0]    len_q [2];
  logic [LenW-1:0]    len_d [2];
  logic [LenW-1:0]    len_clamp;
  logic [3:0]         pin_q, pin_d, pin_mid;
  logic [MODE_W-1:0]  mode_q;
  logic               ce_q, re_q;
  logic [CPR_W-1:0]   cpr_q;

  logic               out_valid_q;
  result_t            out_q, res;

  logic               out_space, rem_start, rem_busy, rem_done, rem_stall;
  logic               can_go, need_wait, pop, load, use_zero, advanced, pulse, wrap;
  logic [NxtW-1:0]    nxt;
  logic signed [SumW-1:0]  dur_x, corr_x, sm1;
  logic signed [32:0]      corr_wide;
  logic [DURATION_BITS-1:0]    dur_sat;
  logic [CORRECTION_BITS-1:0]  corr_sat;

  assign rem_start = cfg_we_i && (cfg_e'(cfg_idx_i) == CFG_PERIOD);

  dps_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .num_i   (cc_q),
    .den_i   ((cfg_wdata_i[CPR_W-1:0] == '0) ? CPR_W'(1) : cfg_wdata_i[CPR_W-1:0]),
    .busy_o  (rem_busy),
    .done_o  (rem_done),
    .rem_o   (rem_val)
  );

  assign rem_stall = rem_busy || rem_start;
  assign out_space = !out_valid_q || m_axis_tready;
  assign can_go    = q_valid_i && out_space && !rem_stall;
  assign need_wait = (q_item_i.op == OP_START) && pend_q && !hold_q;
  assign pop       = can_go && !need_wait;
  assign q_pop_o   = pop;
  assign hold_d    = q_valid_i && (q_item_i.op == OP_START) && pend_q && !pop;

  assign nxt    = NxtW'(cur_q) + NxtW'(1);
  assign wrap   = (nxt >= NxtW'(len_q[act_q]));
  assign period = (cpr_q == '0) ? CPR_W'(1) : cpr_q;
  assign cc_inc = cc_q + CPR_W'(1);

  // limit minus one of the step being loaded, floored at zero
  assign load_entry = use_zero ? zero_entry_q : next_entry_q;
  assign dur_x  = SumW'(load_entry[DURATION_BITS-1:0]);
  assign corr_x = ce_q ? SumW'($signed(load_entry[EntryW-1 -: CORRECTION_BITS])) : '0;
  assign sm1    = dur_x + corr_x - SumW'(1);
  assign left_load = sm1[SumW-1] ? '0 : sm1[LeftW-1:0];

  // saturation of written entries
  assign corr_wide = 33'(q_item_i.step_correction);
  assign dur_sat   = ((q_item_i.step_duration >> DURATION_BITS) != '0)
                   ? {DURATION_BITS{1'b1}} : q_item_i.step_duration[DURATION_BITS-1:0];
  assign corr_sat  = (corr_wide > CorrMax) ? CORRECTION_BITS'(CorrMax)
                   : (corr_wide < CorrMin) ? CORRECTION_BITS'(CorrMin)
                   : CORRECTION_BITS'(corr_wide);

  always_comb begin
    if (q_item_i.pattern_length == '0) begin
      len_clamp = LenW'(1);
    end else if (int'(q_item_i.pattern_length) > MAX_STEPS) begin
      len_clamp = LenW'(MAX_STEPS);
    end else begin
      len_clamp = LenW'(q_item_i.pattern_length);
    end
  end

  always_comb begin
    cur_d    = cur_q;
    left_d   = left_q;
    act_d    = act_q;
    pend_d   = pend_q;
    cc_d     = cc_q;
    len_d    = len_q;
    pin_mid  = pin_q;
    pin_d    = pin_q;
    advanced = 1'b0;
    pulse    = 1'b0;
    mem_we   = 1'b0;
    waddr    = '0;
    wdata    = '0;
    load     = 1'b0;
    use_zero = 1'b0;
    if (rem_done) begin
      cc_d = rem_val;
    end
    if (pop) begin
      unique case (q_item_i.op)
        OP_TICK: begin
          if (mode_q == MODE_RUN) begin
            if (left_q == '0) begin
              advanced = 1'b1;
              load     = 1'b1;
              if (wrap) begin
                use_zero = 1'b1;
                cur_d    = '0;
                if (pend_q) begin
                  act_d  = ~act_q;
                  pend_d = 1'b0;
                end
                if (re_q) begin
                  cc_d  = (cc_inc == period) ? '0 : cc_inc;
                  pulse = (cc_inc == period);
                end
              end else begin
                cur_d = nxt[StepW-1:0];
              end
            end else begin
              left_d = left_q - LeftW'(1);
            end
          end
        end
        OP_WRITE: begin
          if (int'(q_item_i.entry_index) < MAX_STEPS) begin
            mem_we = 1'b1;
            waddr  = {~act_q, StepW'(q_item_i.entry_index)};
            wdata  = {corr_sat, q_item_i.step_pins, dur_sat};
          end
        end
        OP_COMMIT: begin
          len_d[~act_q] = len_clamp;
          pend_d        = 1'b1;
        end
        OP_START: begin
          cc_d     = '0;
          load     = 1'b1;
          use_zero = 1'b1;
          cur_d    = '0;
        end
        OP_SELECT: begin
          act_d = q_item_i.bank_choice;
        end
        default: begin
        end
      endcase
      if (load) begin
        left_d  = left_load;
        pin_mid = {pin_q[3], load_entry[DURATION_BITS +: PINS_W]};
      end
      unique case (mode_q)
        MODE_IDLE: pin_d = '0;
        MODE_HIGH: pin_d = '1;
        default:   pin_d = pin_mid;
      endcase
    end
  end

  // prefetch addresses follow the state after this cycle
  assign addr_a = {act_d, cur_d + StepW'(1)};
  assign addr_b = {(hold_d || !pend_d) ? act_d : ~act_d, StepW'(0)};

  always_comb begin
    res.pin_levels     = pin_d[PINS_W-1:0];
    res.led_level      = pin_d[3];
    res.step_now       = STEP_OUT_W'(cur_d);
    res.bank_now       = act_d;
    res.step_advanced  = advanced;
    res.report_pulse   = pulse;
    res.switch_waiting = pend_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      left_q      <= '0;
      act_q       <= 1'b0;
      pend_q      <= 1'b0;
      hold_q      <= 1'b0;
      cc_q        <= '0;
      len_q[0]    <= LenW'(1);
      len_q[1]    <= LenW'(1);
      pin_q       <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_IDLE;
      ce_q        <= 1'b0;
      re_q        <= 1'b0;
      cpr_q       <= CPR_W'(1);
    end else begin
      cur_q  <= cur_d;
      left_q <= left_d;
      act_q  <= act_d;
      pend_q <= pend_d;
      hold_q <= hold_d;
      cc_q   <= cc_d;
      len_q  <= len_d;
      pin_q  <= pin_d;
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CFG_RUN_MODE:  mode_q <= cfg_wdata_i[MODE_W-1:0];
          CFG_CORR_EN:   ce_q   <= cfg_wdata_i[0];
          CFG_REPORT_EN: re_q   <= cfg_wdata_i[0];
          CFG_PERIOD:    cpr_q  <= cfg_wdata_i[CPR_W-1:0];
        endcase
      end
    end
  end

  // memory with registered read ports, write data forwarded on a same-cycle hit
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[waddr] <= wdata;
    end
    next_entry_q <= (mem_we && (waddr == addr_a)) ? wdata : entry_mem[addr_a];
    zero_entry_q <= (mem_we && (waddr == addr_b)) ? wdata : entry_mem[addr_b];
    if (pop) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

/* src/double_buffered_pattern_sequencer.sv */
// double_buffered_pattern_sequencer: top level, front end queue feeding the execution back end
// depends on dps_pkg, dps_front, dps_back (and dps_rem below it)
`default_nettype none

// Plays a table of timed 3-pin steps from one of two banks while the other bank is rewritten.
// Each input word (tick, entry write, length commit, start, bank select) gives one result word.
// Throughput is one word per clock unless an output stall, remainder or start wait holds it:
// the front queue takes a word while the back end executes the previous one, and the two-word
// queue rides out short output stalls. An accepted word waits in the front queue; its result
// word is registered at the output when the back end executes it. Step entries live in a
// two-read-port memory; the entries of the following step and of step 0 are prefetched each
// cycle, so a step change does not stall. A start word that arrives while a bank switch is
// pending waits until step 0 of the active bank is fetched. A write to cycles_per_report starts
// a serial remainder of the cycle counter; no word executes in the write cycle or during it.
module double_buffered_pattern_sequencer #(
  parameter int MAX_STEPS       = dps_pkg::MaxStepsDef,
  parameter int DURATION_BITS   = dps_pkg::DurationBitsDef,
  parameter int CORRECTION_BITS = dps_pkg::CorrectionBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dps_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry_index, step_duration, step_pins, step_correction, pattern_length, bank_choice
  input  logic [dps_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // func
  input  logic [dps_pkg::FUNC_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pin_levels, led_level, step_now, bank_now, step_advanced, report_pulse, switch_waiting
  output logic [dps_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import dps_pkg::*;

  logic   q_valid;
  logic   q_pop;
  item_t  q_item;

  dps_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  dps_back #(
    .MAX_STEPS       (MAX_STEPS),
    .DURATION_BITS   (DURATION_BITS),
    .CORRECTION_BITS (CORRECTION_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_full_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_valid)
    else $error("input stalled with empty queue");

  a_pulse_at_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[12]) |-> (m_axis_tdata[11] && (m_axis_tdata[9:4] == '0)))
    else $error("report pulse without wrap to first step");
`endif

endmodule

`default_nettype wire
